/* design/qef_pkg.sv */
// Shared types, constants and state codes for the plane error accumulator.
`default_nettype none

package qef_pkg;

  localparam int FRAC_BITS = 16;

  localparam int PW   = 32;                    // register and input field width
  localparam int DIFW = PW + 1;                // p - v, exact
  localparam int PRW  = 2 * DIFW;              // shared multiplier product
  localparam int DW   = 64;                    // 2^(2F) + |g|^2 always fits
  localparam int QW   = 48;                    // quotient / running sum width
  localparam int MW   = 65 - FRAC_BITS;        // rounded |e|
  localparam int LW   = (MW + 1) / 2;          // low half of m
  localparam int HW   = MW - LW;               // high half of m
  localparam int AW   = 131 - 2 * FRAC_BITS;   // accumulator, holds e, den and m^2
  localparam int SH   = QW - FRAC_BITS;        // m^2 bits above the divider's low part
  localparam int CMPW = (AW > DW + SH) ? AW : DW + SH;
  localparam int CIW  = 2;                     // config index width
  localparam int SCW  = 2;                     // step counter width

  localparam logic [QW-1:0] SUM_MAX = {QW{1'b1}};

  localparam logic [CIW-1:0] CFG_POINT_X      = 2'd0;
  localparam logic [CIW-1:0] CFG_POINT_Y      = 2'd1;
  localparam logic [CIW-1:0] CFG_POINT_Z      = 2'd2;
  localparam logic [CIW-1:0] CFG_POINT_OFFSET = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_RND,
    S_DEN,
    S_SQR,
    S_CHK,
    S_DIV,
    S_ACC
  } qef_state_e;

  typedef struct packed {
    logic signed [PW-1:0] sample_x;
    logic signed [PW-1:0] sample_y;
    logic signed [PW-1:0] sample_z;
    logic signed [PW-1:0] grad_x;
    logic signed [PW-1:0] grad_y;
    logic signed [PW-1:0] grad_z;
    logic                 last_sample;
  } qef_in_t;

  typedef struct packed {
    logic [QW-1:0] total_error;
    logic          overflowed;
  } qef_out_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] rem_init;
    logic [QW-1:0] num_lo;
    logic [DW-1:0] den;
  } qef_div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } qef_div_rsp_t;

endpackage

`default_nettype wire

/* design/qef_div.sv */
// Restoring divider, one quotient bit per cycle, 48 quotient bits.
`default_nettype none

module qef_div
  import qef_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire qef_div_req_t req_i,
  output qef_div_rsp_t      rsp_o
);

  localparam int CW = $clog2(QW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [QW-1:0] nlo_q, nlo_d;   // numerator bits shift out, quotient bits shift in

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  always_comb begin
    shifted = {rem_q, nlo_q[QW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nlo_d  = nlo_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem_init;
      den_d  = req_i.den;
      nlo_d  = req_i.num_lo;
    end else if (busy_q) begin
      if (!diff[DW+1]) begin
        rem_d = diff[DW-1:0];
        nlo_d = {nlo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        nlo_d = {nlo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nlo_q <= nlo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = nlo_q;

  // remainder stays below the divisor while iterating
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

`default_nettype wire

/* design/qef_plane_error_accumulator_top.sv */
// Top level: weighted squared plane error accumulator for dual marching cubes.
//
// Config: cfg_we_i writes cfg_wdata_i into point_x, point_y, point_z or
// point_offset (cfg_idx_i 0..3); write only while the block is idle.
// Input: one beat per sample (position, gradient, last_sample), taken when
// in_valid_i is high and in_stall_o is low. in_stall_o stays high while a
// sample is in work. Output: one beat per set, on the sample marked last,
// carrying the saturating 48-bit total and the saturation flag.
// A sample's divide is skipped when its term alone cannot fit 48 bits. One
// signed 33x33 multiplier is shared by the nine products (three run over m
// squared in halves) and the restoring divider sets the pace.
// The finished total sits in an output register; the next sample is taken
// while it waits. If a second total is ready while the first is still
// stalled, the block holds in its last step until the output frees up.
// Reset clears the running sum, the flag, the point registers and the
// output valid.
`default_nettype none

module qef_plane_error_accumulator_top
  import qef_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CIW-1:0]  cfg_idx_i,
  input  wire logic [PW-1:0]   cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire qef_in_t         in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output qef_out_t             out_data_o
);

  qef_state_e state_q, state_d;
  logic [SCW-1:0] step_q, step_d;

  logic signed [PW-1:0] pt_x_q, pt_y_q, pt_z_q, pt_w_q;

  logic signed [PW-1:0]   gx_q, gy_q, gz_q;
  logic signed [DIFW-1:0] dx_q, dy_q, dz_q;
  logic                   last_q;

  logic signed [DIFW-1:0] opa, opb;
  logic signed [PRW-1:0]  prod_q, prod_d;
  logic signed [AW-1:0]   acc_q, acc_d, addend;
  logic [AW-1:0]          acc_u, rnd_base, rnd_inc, rnd_sum;
  logic [MW-1:0]          m_q, m_d;
  logic [DW-1:0]          den_q, den_d;
  logic                   big_q, big_d, big_now;
  logic [QW-1:0]          sum_q, sum_d;
  logic                   sat_q, sat_d;
  logic [QW:0]            sum_nx;
  logic                   ovf;
  qef_out_t               out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  qef_div_req_t div_req;
  qef_div_rsp_t div_rsp;

  qef_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_q)
      S_ERR: begin
        unique case (step_q)
          2'd0: begin opa = DIFW'(gx_q); opb = dx_q; end
          2'd1: begin opa = DIFW'(gy_q); opb = dy_q; end
          2'd2: begin opa = DIFW'(gz_q); opb = dz_q; end
          default: ;
        endcase
      end
      S_DEN: begin
        unique case (step_q)
          2'd0: begin opa = DIFW'(gx_q); opb = DIFW'(gx_q); end
          2'd1: begin opa = DIFW'(gy_q); opb = DIFW'(gy_q); end
          2'd2: begin opa = DIFW'(gz_q); opb = DIFW'(gz_q); end
          default: ;
        endcase
      end
      S_SQR: begin
        unique case (step_q)
          2'd0: begin
            opa = $signed({{(DIFW-HW){1'b0}}, m_q[MW-1:LW]});
            opb = $signed({{(DIFW-HW){1'b0}}, m_q[MW-1:LW]});
          end
          2'd1: begin
            opa = $signed({{(DIFW-HW){1'b0}}, m_q[MW-1:LW]});
            opb = $signed({{(DIFW-LW){1'b0}}, m_q[LW-1:0]});
          end
          2'd2: begin
            opa = $signed({{(DIFW-LW){1'b0}}, m_q[LW-1:0]});
            opb = $signed({{(DIFW-LW){1'b0}}, m_q[LW-1:0]});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    prod_d = opa * opb;
  end

  // product from the previous step, weighted for m^2 assembly
  always_comb begin
    addend = AW'(prod_q);
    if (state_q == S_SQR) begin
      unique case (step_q)
        2'd1:    addend = AW'(prod_q) <<< (2 * LW);   // mh*mh
        2'd2:    addend = AW'(prod_q) <<< (LW + 1);   // 2*mh*ml
        default: addend = AW'(prod_q);                // ml*ml
      endcase
    end
  end

  always_comb begin
    acc_u    = $unsigned(acc_q);
    // |e| + half, with |e| of a negative e folded into ~e + 1
    rnd_base = acc_q[AW-1] ? ~acc_u : acc_u;
    rnd_inc  = AW'(1) << (FRAC_BITS - 1);
    if (acc_q[AW-1]) begin
      rnd_inc = rnd_inc + AW'(1);
    end
    rnd_sum  = rnd_base + rnd_inc;
    big_now  = CMPW'(acc_u) >= (CMPW'(den_q) << SH);
    sum_nx   = {1'b0, sum_q} + {1'b0, div_rsp.quot};
    ovf      = big_q | sum_nx[QW];
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    acc_d       = acc_q;
    m_d         = m_q;
    den_d       = den_q;
    big_d       = big_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;

    div_req.start    = 1'b0;
    div_req.rem_init = DW'(acc_u >> SH);
    div_req.num_lo   = QW'(acc_u) << FRAC_BITS;
    div_req.den      = den_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ERR;
          step_d  = '0;
        end
      end
      S_ERR: begin
        if (step_q == '0) begin
          acc_d = -(AW'(pt_w_q) <<< FRAC_BITS);
        end else begin
          acc_d = acc_q + addend;
        end
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        m_d     = rnd_sum[FRAC_BITS +: MW];
        state_d = S_DEN;
        step_d  = '0;
      end
      S_DEN: begin
        if (step_q == '0) begin
          acc_d = '0;
          acc_d[2*FRAC_BITS] = 1'b1;
        end else begin
          acc_d = acc_q + addend;
        end
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (step_q == '0) begin
          den_d = acc_u[DW-1:0];
          acc_d = '0;
        end else begin
          acc_d = acc_q + addend;
        end
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // quotient cannot fit 48 bits: the term saturates, skip the divide
        big_d = big_now;
        if (big_now) begin
          state_d = S_ACC;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (!last_q) begin
          sum_d   = ovf ? SUM_MAX : sum_nx[QW-1:0];
          sat_d   = sat_q | ovf;
          state_d = S_IDLE;
        end else if (!(out_valid_q && out_stall_i)) begin
          out_d.total_error = ovf ? SUM_MAX : sum_nx[QW-1:0];
          out_d.overflowed  = sat_q | ovf;
          out_valid_d       = 1'b1;
          sum_d             = '0;
          sat_d             = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pt_x_q      <= '0;
      pt_y_q      <= '0;
      pt_z_q      <= '0;
      pt_w_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POINT_X:      pt_x_q <= cfg_wdata_i;
          CFG_POINT_Y:      pt_y_q <= cfg_wdata_i;
          CFG_POINT_Z:      pt_z_q <= cfg_wdata_i;
          CFG_POINT_OFFSET: pt_w_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      gx_q   <= in_data_i.grad_x;
      gy_q   <= in_data_i.grad_y;
      gz_q   <= in_data_i.grad_z;
      dx_q   <= DIFW'(pt_x_q) - DIFW'(in_data_i.sample_x);
      dy_q   <= DIFW'(pt_y_q) - DIFW'(in_data_i.sample_y);
      dz_q   <= DIFW'(pt_z_q) - DIFW'(in_data_i.sample_z);
      last_q <= in_data_i.last_sample;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    m_q    <= m_d;
    den_q  <= den_d;
    big_q  <= big_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sat_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> sum_q == SUM_MAX)
    else $error("saturation flag set with sum below max");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC && last_q && out_valid_q && out_stall_i |=> state_q == S_ACC)
    else $error("total dropped while output stalled");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_ACC && $past(last_q))
    else $error("output beat without a last sample");

endmodule

`default_nettype wire
